// ----- rtl/keyframe_timeline_advance_macros.svh -----
// Assertion macros shared by the keyframe timeline RTL.
`ifndef KEYFRAME_TIMELINE_ADVANCE_MACROS_SVH
`define KEYFRAME_TIMELINE_ADVANCE_MACROS_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define KTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define KTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kta_pkg.sv -----
// Package with the operation codes, register indexes and fixed widths of the timeline block.
package kta_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] REG_KEYFRAME_COUNT  = 8'd0;
    localparam logic [7:0] REG_LOOP_ENABLE     = 8'd1;
    localparam logic [7:0] REG_SEQUENCE_SPEED  = 8'd2;
    localparam logic [7:0] REG_POSE_SPEED      = 8'd3;

    // Fixed field widths.
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 16;
    localparam int COUNT_W = 5;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

endpackage

// ----- rtl/keyframe_timeline_advance.sv -----
// Keyframe timeline advance: duration table, playback time, keyframe walk and blend weight.
// One beat in gives one beat out. Start, load, ignored ticks and unused ops go straight to
// the output handshake. A tick sums the durations of the N keyframes in use (one table read
// a cycle), scales the elapsed time by both speeds, then steps through the keyframes (one
// table read and compare per step); a looping tick may skip whole passes (a 32-step remainder
// unit and a table reread). The weight comes from a FRAC_BITS-step restoring divider, which
// a tick that stops on the last keyframe skips. The block takes a new beat only once the
// previous one has finished its work; the result register lets that happen while a result
// still waits. Configuration writes are taken only while no beat is being worked on.
`include "keyframe_timeline_advance_macros.svh"

module keyframe_timeline_advance #(
    parameter int MAX_KEYFRAMES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] entry_index, [35:4] entry_duration, [67:36] elapsed, [71:68] zero
    input  logic [71:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] current_index, [7:4] next_index, [24:8] blend_weight, [25] running, [31:26] zero
    output logic [31:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW  = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CW  = $clog2(MAX_KEYFRAMES + 1);
    localparam int TW  = kta_pkg::TIME_W + IW;
    localparam int WW  = FRAC_BITS + 1;
    localparam int DCW = $clog2(FRAC_BITS);
    localparam int MCW = $clog2(kta_pkg::TIME_W);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SUM  = 10'b00_0000_0010,
        ST_MUL1 = 10'b00_0000_0100,
        ST_MUL2 = 10'b00_0000_1000,
        ST_ADD  = 10'b00_0001_0000,
        ST_RD   = 10'b00_0010_0000,
        ST_CMP  = 10'b00_0100_0000,
        ST_MOD  = 10'b00_1000_0000,
        ST_DIV  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [kta_pkg::COUNT_W-1:0] kcount_reg;
    logic                        loop_reg;
    logic [kta_pkg::SPEED_W-1:0] seq_speed_reg;
    logic [kta_pkg::SPEED_W-1:0] pose_speed_reg;

    // Playback state.
    logic [IW-1:0] frame_now_reg;
    logic [IW-1:0] frame_after_reg;
    logic [31:0]   eif_reg;
    logic [WW-1:0] weight_reg;
    logic          playing_reg;

    // Working registers of a tick.
    logic [31:0]   el_reg;
    logic [31:0]   t_reg;
    logic [TW-1:0] total_reg;
    logic [CW-1:0] k_reg;
    logic          pend_reg;
    logic [47:0]   p1_reg;
    logic [47:0]   plo_reg;
    logic [31:0]   phi_reg;
    logic [TW-1:0] r_reg;
    logic [31:0]   x_reg;
    logic [MCW-1:0] mcnt_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   d_reg;
    logic [WW-1:0] q_reg;
    logic [DCW-1:0] dcnt_reg;

    // Result register.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // Duration table.
    logic [31:0]   dur_mem [MAX_KEYFRAMES];
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;

    // Input fields.
    logic [1:0]  in_op;
    logic [3:0]  in_idx;
    logic [31:0] in_dur;
    logic [31:0] in_el;
    logic        in_accept;

    assign in_op  = s_tuser;
    assign in_idx = s_tdata[3:0];
    assign in_dur = s_tdata[35:4];
    assign in_el  = s_tdata[67:36];

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Count in use, clamped to 1..MAX_KEYFRAMES.
    logic [CW-1:0] n_use;
    always_comb begin
        if (kcount_reg == '0) begin
            n_use = CW'(1);
        end else if (32'(kcount_reg) > MAX_KEYFRAMES) begin
            n_use = CW'(MAX_KEYFRAMES);
        end else begin
            n_use = CW'(kcount_reg);
        end
    end

    // A stored zero duration counts as one unit.
    logic [31:0] dur_fix;
    assign dur_fix = (rd_data_reg == '0) ? 32'd1 : rd_data_reg;

    // Table port: a load writes, the sweep and the keyframe walk read.
    assign mem_we = in_accept && (in_op == kta_pkg::OP_LOAD) && (32'(in_idx) < MAX_KEYFRAMES);
    always_comb begin
        if (state_reg == ST_SUM) begin
            rd_addr = k_reg[IW-1:0];
        end else begin
            rd_addr = frame_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dur_mem[IW'(in_idx)] <= in_dur;
        end
        rd_data_reg <= dur_mem[rd_addr];
    end

    // Time after the tick increment, saturated to 32 bits.
    logic [63:0] prod_sum;
    logic [48:0] t_sum;
    assign prod_sum = {phi_reg, 32'd0} + {16'd0, plo_reg};
    assign t_sum    = 49'(eif_reg) + {1'b0, prod_sum[63:16]};

    // Keyframe step helpers.
    logic [CW-1:0] frame_inc;
    logic [CW-1:0] frame_inc2;
    assign frame_inc  = CW'(frame_now_reg) + CW'(1);
    assign frame_inc2 = frame_inc + CW'(1);

    // One remainder step of (t - 1) mod total.
    logic [TW:0]   mod_r2;
    logic [TW-1:0] mod_r;
    assign mod_r2 = {r_reg, x_reg[31]};
    assign mod_r  = (mod_r2 >= {1'b0, total_reg}) ? TW'(mod_r2 - {1'b0, total_reg})
                                                  : mod_r2[TW-1:0];

    // One quotient bit of the weight division.
    logic [32:0]   div_r2;
    logic          div_bit;
    logic [WW-1:0] div_q;
    assign div_r2  = {rem_reg, 1'b0};
    assign div_bit = (div_r2 >= {1'b0, d_reg});
    assign div_q   = {q_reg[WW-2:0], div_bit};

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kcount_reg     <= kta_pkg::COUNT_RESET;
            loop_reg       <= 1'b0;
            seq_speed_reg  <= kta_pkg::SPEED_RESET;
            pose_speed_reg <= kta_pkg::SPEED_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kta_pkg::REG_KEYFRAME_COUNT: kcount_reg <= cfg_data[kta_pkg::COUNT_W-1:0];
                kta_pkg::REG_LOOP_ENABLE:    loop_reg <= cfg_data[0];
                kta_pkg::REG_SEQUENCE_SPEED: seq_speed_reg <= cfg_data;
                kta_pkg::REG_POSE_SPEED:     pose_speed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            frame_now_reg   <= '0;
            frame_after_reg <= IW'(1);
            eif_reg         <= '0;
            weight_reg      <= '0;
            playing_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            pend_reg        <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (in_op == kta_pkg::OP_TICK && playing_reg) begin
                            // Indices left over from a larger count restart the playback.
                            if (CW'(frame_now_reg) >= n_use || CW'(frame_after_reg) >= n_use) begin
                                frame_now_reg   <= '0;
                                frame_after_reg <= IW'(1);
                                eif_reg         <= '0;
                            end
                            el_reg    <= in_el;
                            total_reg <= '0;
                            k_reg     <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= ST_SUM;
                        end else begin
                            // Everything but a live tick answers right away.
                            if (in_op == kta_pkg::OP_START) begin
                                playing_reg     <= 1'b1;
                                frame_now_reg   <= '0;
                                frame_after_reg <= IW'(1);
                                weight_reg      <= '0;
                                eif_reg         <= '0;
                            end
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SUM: begin
                    // Sum the durations in use, one table read a cycle.
                    if (k_reg < n_use) begin
                        k_reg <= k_reg + CW'(1);
                    end
                    if (pend_reg) begin
                        total_reg <= total_reg + TW'(dur_fix);
                    end
                    pend_reg <= (k_reg < n_use);
                    if (k_reg == n_use && !pend_reg) begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    p1_reg    <= 48'(el_reg) * 48'(seq_speed_reg);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    plo_reg   <= 48'(p1_reg[31:0]) * 48'(pose_speed_reg);
                    phi_reg   <= 32'(p1_reg[47:32]) * 32'(pose_speed_reg);
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    t_reg     <= (t_sum > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : t_sum[31:0];
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (t_reg > dur_fix) begin
                        if (loop_reg && frame_now_reg == '0 && TW'(t_reg) > total_reg) begin
                            // Skip whole passes of the table.
                            r_reg     <= '0;
                            x_reg     <= t_reg - 32'd1;
                            mcnt_reg  <= MCW'(kta_pkg::TIME_W - 1);
                            state_reg <= ST_MOD;
                        end else if (frame_inc >= n_use && !loop_reg) begin
                            // Past the last keyframe without looping: stop.
                            frame_now_reg   <= IW'(n_use - CW'(1));
                            frame_after_reg <= IW'(n_use - CW'(1));
                            weight_reg      <= {1'b1, {FRAC_BITS{1'b0}}};
                            playing_reg     <= 1'b0;
                            eif_reg         <= t_reg - dur_fix;
                            state_reg       <= ST_OUT;
                        end else begin
                            t_reg     <= t_reg - dur_fix;
                            state_reg <= ST_RD;
                            if (frame_inc >= n_use) begin
                                frame_now_reg   <= '0;
                                frame_after_reg <= (n_use == CW'(1)) ? '0 : IW'(1);
                            end else begin
                                frame_now_reg <= IW'(frame_inc);
                                if (frame_inc2 < n_use) begin
                                    frame_after_reg <= IW'(frame_inc2);
                                end else if (loop_reg) begin
                                    frame_after_reg <= '0;
                                end else begin
                                    frame_after_reg <= IW'(n_use - CW'(1));
                                end
                            end
                        end
                    end else begin
                        // Time lies inside the current keyframe: divide for the weight.
                        eif_reg   <= t_reg;
                        d_reg     <= dur_fix;
                        rem_reg   <= (t_reg >= dur_fix) ? t_reg - dur_fix : t_reg;
                        q_reg     <= WW'(t_reg >= dur_fix);
                        dcnt_reg  <= DCW'(FRAC_BITS - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_MOD: begin
                    r_reg    <= mod_r;
                    x_reg    <= {x_reg[30:0], 1'b0};
                    mcnt_reg <= mcnt_reg - MCW'(1);
                    if (mcnt_reg == '0) begin
                        t_reg           <= 32'(mod_r) + 32'd1;
                        frame_after_reg <= (n_use == CW'(1)) ? '0 : IW'(1);
                        state_reg       <= ST_RD;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= div_bit ? 32'(div_r2 - {1'b0, d_reg}) : div_r2[31:0];
                    q_reg    <= div_q;
                    dcnt_reg <= dcnt_reg - DCW'(1);
                    if (dcnt_reg == '0) begin
                        weight_reg <= div_q;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hand the pose to the result register once it is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'd0, playing_reg, 17'(weight_reg),
                            4'(frame_after_reg), 4'(frame_now_reg)};
        end
    end

    // A beat taken in starts work, so the input closes the next cycle.
    `KTA_ASSERT_NEXT(a_busy_after_accept, in_accept, state_reg != ST_IDLE, "input open")
    // The keyframe walk only reads entries inside the count in use.
    `KTA_ASSERT_NOW(a_frame_in_range, state_reg == ST_CMP, CW'(frame_now_reg) < n_use, "frame")
    // The pass remainder stays below the table total.
    `KTA_ASSERT_NOW(a_mod_bound, state_reg == ST_MOD, r_reg < total_reg, "pass remainder")
    // The division remainder stays below the divisor.
    `KTA_ASSERT_NOW(a_div_bound, state_reg == ST_DIV, rem_reg < d_reg, "division remainder")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the keyframe timeline block, with a built-in predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEY = 16;
    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        running;
        logic [16:0] weight;
        logic [3:0]  next_idx;
        logic [3:0]  cur_idx;
    } pose_t;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] dur;
        logic [31:0] el;
        bit          has_pose;
        pose_t       pose;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    keyframe_timeline_advance uut (.*);

    always #10 aclk = ~aclk;

    // Predictor state: table, pose and registers.
    logic [31:0] dur_tab [NKEY];
    logic [31:0] time_in_frame;
    int unsigned frame_cur, frame_nxt;
    logic [16:0] weight_cur;
    bit          playing;
    int unsigned key_count, loop_on, seq_speed, pose_speed_r;

    pose_t expected_poses [$];
    int    mismatches = 0;
    bit    calm = 0;
    bit    hold_off = 0;
    int    accepted_cycles = 0;

    function automatic longint unsigned eff_dur(int unsigned k);
        if (k >= NKEY || dur_tab[k] == 0) return 1;
        return dur_tab[k];
    endfunction

    // Advance the pose by one tick of the given elapsed time.
    function automatic void advance_time(logic [31:0] el);
        int unsigned n;
        longint unsigned total, t, prod;
        logic [127:0] wide;
        n = key_count == 0 ? 1 : (key_count > NKEY ? NKEY : key_count);
        total = 0;
        if (!playing) return;
        if (frame_cur >= n || frame_nxt >= n) begin
            frame_cur = 0;
            frame_nxt = 1;
            time_in_frame = 0;
        end
        for (int k = 0; k < n; k++) total += eff_dur(k);
        wide = 128'(el) * 128'(seq_speed) * 128'(pose_speed_r);
        prod = 64'(wide >> 16);
        t = longint'(time_in_frame) + prod;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        while (t > eff_dur(frame_cur)) begin
            if (loop_on != 0 && frame_cur == 0 && t > total) begin
                t -= total * ((t - 1) / total);
                frame_nxt = 1 % n;
                continue;
            end
            t -= eff_dur(frame_cur);
            frame_cur++;
            if (frame_cur >= n) begin
                if (loop_on != 0) begin
                    frame_cur = 0;
                end else begin
                    frame_cur = n - 1;
                    frame_nxt = n - 1;
                    weight_cur = 17'(1 << FRAC);
                    playing = 0;
                    time_in_frame = t[31:0];
                    return;
                end
            end
            if (loop_on != 0) frame_nxt = (frame_cur + 1) % n;
            else frame_nxt = (frame_cur + 1 < n) ? frame_cur + 1 : n - 1;
        end
        time_in_frame = t[31:0];
        weight_cur = 17'((t << FRAC) / eff_dur(frame_cur));
    endfunction

    function automatic pose_t predict_pose(logic [1:0] op, logic [3:0] idx,
                                           logic [31:0] dur, logic [31:0] el);
        pose_t p;
        if (op == kta_pkg::OP_START) begin
            playing = 1;
            frame_cur = 0;
            frame_nxt = 1;
            weight_cur = 0;
            time_in_frame = 0;
        end else if (op == kta_pkg::OP_LOAD) begin
            dur_tab[idx] = dur;
        end else if (op == kta_pkg::OP_TICK) begin
            advance_time(el);
        end
        p.cur_idx = frame_cur[3:0];
        p.next_idx = frame_nxt[3:0];
        p.weight = weight_cur;
        p.running = playing;
        return p;
    endfunction

    task automatic send_beat(logic [1:0] op, logic [3:0] idx, logic [31:0] dur,
                             logic [31:0] el, bit has_pose, pose_t pose);
        pose_t p;
        while (!calm && $urandom_range(99) < 28) @(posedge aclk);
        p = predict_pose(op, idx, dur, el);
        if (has_pose && p !== pose) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row op %0d: exp %h, predictor %h", op, pose, p);
        end
        expected_poses.push_back(p);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, el, dur, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Drop valid between beats; the block is busy and cannot take a new beat here anyway.
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (index)
            kta_pkg::REG_KEYFRAME_COUNT: key_count = value[4:0];
            kta_pkg::REG_LOOP_ENABLE:    loop_on = value[0];
            kta_pkg::REG_SEQUENCE_SPEED: seq_speed = value;
            kta_pkg::REG_POSE_SPEED:     pose_speed_r = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        pose_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[25:0];
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_poses.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp cur %0d nxt %0d w %0d run %0d, ",
                                  "got cur %0d nxt %0d w %0d run %0d"},
                                 want.cur_idx, want.next_idx, want.weight, want.running,
                                 got.cur_idx, got.next_idx, got.weight, got.running);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && (calm || $urandom_range(99) >= 28);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            accepted_cycles <= 0;
        else
            accepted_cycles <= accepted_cycles + 1;
        if (accepted_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Load entries 0..n-1 with short random durations, some zero.
    task automatic load_table(int unsigned n);
        pose_t none;
        none = '0;
        for (int k = 0; k < n; k++)
            send_beat(kta_pkg::OP_LOAD, 4'(k), ($urandom_range(9) == 0) ? 32'd0 :
                      32'($urandom_range(32'h30000)), 32'd0, 1'b0, none);
    endtask

    task automatic random_phase(int items);
        pose_t none;
        logic [1:0] op;
        logic [31:0] el;
        int unsigned r, n;
        none = '0;
        n = key_count == 0 ? 1 : (key_count > NKEY ? NKEY : key_count);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            op = r < 12 ? kta_pkg::OP_START : r < 20 ? kta_pkg::OP_LOAD :
                 r < 97 ? kta_pkg::OP_TICK : kta_pkg::OP_UNUSED;
            case ($urandom_range(3))
                0: el = $urandom;
                1: el = $urandom_range(32'h800);
                default: el = $urandom_range(32'h20000);
            endcase
            // Loads stay inside the loaded range so no unwritten entry is read.
            send_beat(op, 4'($urandom_range(n - 1)), $urandom, el, 1'b0, none);
        end
    endtask

    initial begin
        row_t rows [$];
        pose_t p0;
        row_t rw;
        for (int k = 0; k < NKEY; k++) dur_tab[k] = 0;
        time_in_frame = 0; frame_cur = 0; frame_nxt = 1; weight_cur = 0; playing = 0;
        key_count = 1; loop_on = 0; seq_speed = 256; pose_speed_r = 256;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; poses typed in where obvious.
        p0 = '{running: 1'b0, weight: 17'd0, next_idx: 4'd1, cur_idx: 4'd0};
        rows.push_back('{kta_pkg::OP_UNUSED, 4'd0, 32'd0, 32'd0, 1'b1, p0});
        rows.push_back('{kta_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, p0});
        rows.push_back('{kta_pkg::OP_LOAD, 4'd0, 32'h0001_0000, 32'd0, 1'b1, p0});
        rows.push_back('{kta_pkg::OP_LOAD, 4'd15, 32'hFFFF_FFFF, 32'd0, 1'b1, p0});
        p0.running = 1;
        rows.push_back('{kta_pkg::OP_START, 4'd0, 32'd0, 32'd0, 1'b1, p0});
        rows.push_back('{kta_pkg::OP_TICK, 4'd0, 32'd0, 32'h0000_8000, 1'b0, p0});
        rows.push_back('{kta_pkg::OP_TICK, 4'd0, 32'd0, 32'd0, 1'b0, p0});
        p0 = '{running: 1'b0, weight: 17'h10000, next_idx: 4'd0, cur_idx: 4'd0};
        rows.push_back('{kta_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, p0});
        rows.push_back('{kta_pkg::OP_TICK, 4'd0, 32'd0, 32'd5, 1'b1, p0});
        foreach (rows[i]) begin
            rw = rows[i];
            send_beat(rw.op, rw.idx, rw.dur, rw.el, rw.has_pose, rw.pose);
        end
        wait_drained();

        // Looping over sixteen frames, zero durations, full speed extremes.
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd16);
        write_reg(kta_pkg::REG_LOOP_ENABLE, 16'd1);
        write_reg(kta_pkg::REG_SEQUENCE_SPEED, 16'hFFFF);
        write_reg(kta_pkg::REG_POSE_SPEED, 16'd0);
        load_table(16);
        send_beat(kta_pkg::OP_LOAD, 4'd3, 32'd0, 32'd0, 1'b0, p0);
        send_beat(kta_pkg::OP_START, 4'd0, 32'd0, 32'd0, 1'b0, p0);
        send_beat(kta_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, p0);
        wait_drained();
        write_reg(kta_pkg::REG_POSE_SPEED, 16'hFFFF);
        send_beat(kta_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, p0);
        send_beat(kta_pkg::OP_TICK, 4'd0, 32'd0, 32'd1, 1'b0, p0);
        wait_drained();
        write_reg(kta_pkg::REG_SEQUENCE_SPEED, 16'd256);
        write_reg(kta_pkg::REG_POSE_SPEED, 16'd256);
        random_phase(150);
        wait_drained();

        // Pressure: the receiver holds off while beats keep coming.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            random_phase(10);
        join
        wait_drained();

        // Non-looped, count shrinks to make stale indices, zero count.
        write_reg(kta_pkg::REG_LOOP_ENABLE, 16'd0);
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd4);
        calm = 1;
        random_phase(150);
        calm = 0;
        wait_drained();
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd0);
        random_phase(80);
        wait_drained();
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd31);
        write_reg(kta_pkg::REG_LOOP_ENABLE, 16'd1);
        write_reg(kta_pkg::REG_SEQUENCE_SPEED, 16'd700);
        random_phase(150);
        wait_drained();
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd2);
        write_reg(kta_pkg::REG_POSE_SPEED, 16'd40);
        random_phase(120);
        wait_drained();
        write_reg(kta_pkg::REG_KEYFRAME_COUNT, 16'd9);
        write_reg(kta_pkg::REG_LOOP_ENABLE, 16'd0);
        write_reg(kta_pkg::REG_SEQUENCE_SPEED, 16'd256);
        random_phase(120);
        wait_drained();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- keyframe_timeline_advance.f -----
+incdir+rtl
rtl/kta_pkg.sv
rtl/keyframe_timeline_advance.sv
verif/tb_top.sv
